### hdl/cfaxc_pkg.sv
`timescale 1ns / 1ps

package cfaxc_pkg;

	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int SLOT_W     = 3;
	localparam int CCNT_W     = 4;
	localparam int RCNT_W     = 16;
	localparam int CLAMP_W    = 5;
	localparam int OP_W       = 33;
	localparam int PROD_W     = 66;
	localparam int SUM_W      = 67;
	localparam int ACC_W      = 48;
	localparam int FRAC       = 16;
	localparam int NMUL       = 4;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_MATRIX = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONJ_MATRIX  = 3'd0,
		REG_CONJ_VECTOR  = 3'd1,
		REG_ALPHA_REAL   = 3'd2,
		REG_ALPHA_IMAG   = 3'd3,
		REG_COLUMN_COUNT = 3'd4,
		REG_ROW_COUNT    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MSEL_ITEM = 2'd0,
		MSEL_HI   = 2'd1,
		MSEL_LO   = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic                  conj_matrix;
		logic                  conj_vector;
		logic [CFG_DATA_W-1:0] alpha_real;
		logic [CFG_DATA_W-1:0] alpha_imag;
		logic [CCNT_W-1:0]     column_count;
		logic [RCNT_W-1:0]     row_count;
	} cfg_t;

	typedef struct packed {
		logic     capture;
		logic     store_we;
		logic     first;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_en;
		logic     hsum_en;
		logic     lsum_en;
		logic     out_load;
		logic     last_row;
	} dp_cmd_t;

endpackage

### hdl/cfaxc_cfg_regs.sv
`timescale 1ns / 1ps

module cfaxc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [cfaxc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [cfaxc_pkg::CFG_DATA_W-1:0]  wr_data,
	output cfaxc_pkg::cfg_t                    cfg
);

	cfaxc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conj_matrix  <= 1'b0;
			cfg_q.conj_vector  <= 1'b0;
			cfg_q.alpha_real   <= '0;
			cfg_q.alpha_imag   <= '0;
			cfg_q.column_count <= cfaxc_pkg::CCNT_W'(1);
			cfg_q.row_count    <= cfaxc_pkg::RCNT_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				cfaxc_pkg::REG_CONJ_MATRIX:  cfg_q.conj_matrix  <= wr_data[0];
				cfaxc_pkg::REG_CONJ_VECTOR:  cfg_q.conj_vector  <= wr_data[0];
				cfaxc_pkg::REG_ALPHA_REAL:   cfg_q.alpha_real   <= wr_data;
				cfaxc_pkg::REG_ALPHA_IMAG:   cfg_q.alpha_imag   <= wr_data;
				cfaxc_pkg::REG_COLUMN_COUNT: cfg_q.column_count <= wr_data[cfaxc_pkg::CCNT_W-1:0];
				cfaxc_pkg::REG_ROW_COUNT:    cfg_q.row_count    <= wr_data[cfaxc_pkg::RCNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/cfaxc_ctrl.sv
`timescale 1ns / 1ps

module cfaxc_ctrl #(
	parameter int MAX_COLUMNS = 8,
	localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfaxc_pkg::cfg_t      cfg,
	input  logic                 in_valid,
	input  logic                 opcode,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output cfaxc_pkg::dp_cmd_t   cmd,
	output logic [IDX_W-1:0]     col
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_ACC  = 7'b0000100,
		ST_FHI  = 7'b0001000,
		ST_FLO  = 7'b0010000,
		ST_SUM  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t                           state_q, state_nx;
	logic [IDX_W-1:0]                 col_cnt_q;
	logic [cfaxc_pkg::RCNT_W-1:0]     row_cnt_q;
	logic                             first_q, last_col_q, row_last_q, out_valid_q;

	logic [cfaxc_pkg::CLAMP_W-1:0]    cc_c, cols_c, cnt_c, col_c;
	logic [cfaxc_pkg::RCNT_W-1:0]     rows_c;
	logic                             last_col_c, row_end_c, accept_c, out_free_c;

	always_comb begin
		cc_c = cfaxc_pkg::CLAMP_W'(cfg.column_count);
		if (cc_c == '0) begin
			cols_c = cfaxc_pkg::CLAMP_W'(1);
		end else if (cc_c > cfaxc_pkg::CLAMP_W'(MAX_COLUMNS)) begin
			cols_c = cfaxc_pkg::CLAMP_W'(MAX_COLUMNS);
		end else begin
			cols_c = cc_c;
		end
		cnt_c = cfaxc_pkg::CLAMP_W'(col_cnt_q);
		col_c = (cnt_c >= cols_c) ? cols_c - cfaxc_pkg::CLAMP_W'(1) : cnt_c;
		last_col_c = (col_c + cfaxc_pkg::CLAMP_W'(1)) >= cols_c;
		rows_c = (cfg.row_count == '0) ? cfaxc_pkg::RCNT_W'(1) : cfg.row_count;
		row_end_c = ({1'b0, row_cnt_q} + (cfaxc_pkg::RCNT_W+1)'(1)) >= {1'b0, rows_c};
	end

	assign col        = IDX_W'(col_c);
	assign accept_c   = in_valid && (state_q == ST_IDLE);
	assign out_free_c = !out_valid_q || !out_stall;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		cmd.mul_sel  = cfaxc_pkg::MSEL_ITEM;
		cmd.first    = first_q;
		cmd.last_row = row_last_q;
		case (state_q)
			ST_IDLE: begin
				cmd.capture  = accept_c && (opcode == cfaxc_pkg::OP_MATRIX);
				cmd.store_we = accept_c && (opcode == cfaxc_pkg::OP_LOAD);
				if (cmd.capture) begin
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = cfaxc_pkg::MSEL_ITEM;
				state_nx = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_en = 1'b1;
				state_nx = last_col_q ? ST_FHI : ST_IDLE;
			end
			ST_FHI: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = cfaxc_pkg::MSEL_HI;
				state_nx = ST_FLO;
			end
			ST_FLO: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = cfaxc_pkg::MSEL_LO;
				cmd.hsum_en = 1'b1;
				state_nx = ST_SUM;
			end
			ST_SUM: begin
				cmd.lsum_en = 1'b1;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_free_c) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_cnt_q   <= '0;
			row_cnt_q   <= '0;
			first_q     <= 1'b0;
			last_col_q  <= 1'b0;
			row_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.capture) begin
				first_q    <= (col_c == '0);
				last_col_q <= last_col_c;
				if (last_col_c) begin
					col_cnt_q  <= '0;
					row_last_q <= row_end_c;
					row_cnt_q  <= row_end_c ? '0 : row_cnt_q + cfaxc_pkg::RCNT_W'(1);
				end else begin
					col_cnt_q <= IDX_W'(col_c + cfaxc_pkg::CLAMP_W'(1));
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

### hdl/cfaxc_dpath.sv
`timescale 1ns / 1ps

module cfaxc_dpath #(
	parameter int MAX_COLUMNS = 8,
	parameter int COMPONENT_BITS = 32,
	localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cfaxc_pkg::cfg_t                   cfg,
	input  cfaxc_pkg::dp_cmd_t                cmd,
	input  logic [IDX_W-1:0]                  col,
	input  logic [cfaxc_pkg::SLOT_W-1:0]      column_slot,
	input  logic [COMPONENT_BITS-1:0]         value_real,
	input  logic [COMPONENT_BITS-1:0]         value_imag,
	input  logic [COMPONENT_BITS-1:0]         old_y_real,
	input  logic [COMPONENT_BITS-1:0]         old_y_imag,
	output logic [COMPONENT_BITS-1:0]         new_y_real,
	output logic [COMPONENT_BITS-1:0]         new_y_imag,
	output logic                              saturated,
	output logic                              last_row
);

	localparam int OP_W   = cfaxc_pkg::OP_W;
	localparam int PROD_W = cfaxc_pkg::PROD_W;
	localparam int SUM_W  = cfaxc_pkg::SUM_W;
	localparam int ACC_W  = cfaxc_pkg::ACC_W;
	localparam int FRAC   = cfaxc_pkg::FRAC;
	localparam int NMUL   = cfaxc_pkg::NMUL;
	localparam logic signed [SUM_W-1:0] Y_MAX =
		(SUM_W'(1) <<< (COMPONENT_BITS - 1)) - SUM_W'(1);
	localparam logic signed [SUM_W-1:0] Y_MIN = -Y_MAX - SUM_W'(1);

	logic [COMPONENT_BITS-1:0] st_re_q [MAX_COLUMNS];
	logic [COMPONENT_BITS-1:0] st_im_q [MAX_COLUMNS];

	logic signed [OP_W-1:0]    ar_q, ai_q, xr_q, xi_q;
	logic signed [COMPONENT_BITS-1:0] yr_q, yi_q;
	logic signed [OP_W-1:0]    ma [NMUL];
	logic signed [OP_W-1:0]    mb [NMUL];
	logic signed [PROD_W-1:0]  p_q [NMUL];
	logic [ACC_W-1:0]          acc_r_q, acc_i_q, tr_c, ti_c;
	logic signed [OP_W-1:0]    alr_c, ali_c, accr_hi_c, acci_hi_c, accr_lo_c, acci_lo_c;
	logic signed [SUM_W-1:0]   hs_r_q, hs_i_q, ls_r_q, ls_i_q, tot_r_c, tot_i_c;
	logic [COMPONENT_BITS-1:0] clip_r_c, clip_i_c;
	logic                      sat_r_c, sat_i_c;
	logic [COMPONENT_BITS-1:0] new_r_q, new_i_q;
	logic                      sat_q, last_q;
	logic [IDX_W-1:0]          slot_idx_c;

	assign slot_idx_c = IDX_W'(column_slot);

	always_ff @(posedge clk) begin
		if (cmd.store_we && (cfaxc_pkg::CLAMP_W'(column_slot) < cfaxc_pkg::CLAMP_W'(MAX_COLUMNS))) begin
			st_re_q[slot_idx_c] <= value_real;
			st_im_q[slot_idx_c] <= value_imag;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ar_q <= OP_W'($signed(value_real));
			ai_q <= cfg.conj_matrix ? -OP_W'($signed(value_imag)) : OP_W'($signed(value_imag));
			xr_q <= OP_W'($signed(st_re_q[col]));
			xi_q <= cfg.conj_vector ? -OP_W'($signed(st_im_q[col]))
			                        : OP_W'($signed(st_im_q[col]));
			yr_q <= $signed(old_y_real);
			yi_q <= $signed(old_y_imag);
		end
	end

	always_comb begin
		alr_c     = OP_W'($signed(cfg.alpha_real[COMPONENT_BITS-1:0]));
		ali_c     = OP_W'($signed(cfg.alpha_imag[COMPONENT_BITS-1:0]));
		accr_hi_c = OP_W'($signed(acc_r_q[ACC_W-1:FRAC]));
		acci_hi_c = OP_W'($signed(acc_i_q[ACC_W-1:FRAC]));
		accr_lo_c = OP_W'(acc_r_q[FRAC-1:0]);
		acci_lo_c = OP_W'(acc_i_q[FRAC-1:0]);
		case (cmd.mul_sel)
			cfaxc_pkg::MSEL_HI: begin
				ma[0] = alr_c; mb[0] = accr_hi_c;
				ma[1] = ali_c; mb[1] = acci_hi_c;
				ma[2] = alr_c; mb[2] = acci_hi_c;
				ma[3] = ali_c; mb[3] = accr_hi_c;
			end
			cfaxc_pkg::MSEL_LO: begin
				ma[0] = alr_c; mb[0] = accr_lo_c;
				ma[1] = ali_c; mb[1] = acci_lo_c;
				ma[2] = alr_c; mb[2] = acci_lo_c;
				ma[3] = ali_c; mb[3] = accr_lo_c;
			end
			default: begin
				ma[0] = ar_q; mb[0] = xr_q;
				ma[1] = ai_q; mb[1] = xi_q;
				ma[2] = ar_q; mb[2] = xi_q;
				ma[3] = ai_q; mb[3] = xr_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			for (int k = 0; k < NMUL; k++) begin
				p_q[k] <= ma[k] * mb[k];
			end
		end
	end

	assign tr_c = p_q[0][FRAC+ACC_W-1:FRAC] - p_q[1][FRAC+ACC_W-1:FRAC];
	assign ti_c = p_q[2][FRAC+ACC_W-1:FRAC] + p_q[3][FRAC+ACC_W-1:FRAC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_r_q <= '0;
			acc_i_q <= '0;
		end else if (cmd.acc_en) begin
			acc_r_q <= cmd.first ? tr_c : acc_r_q + tr_c;
			acc_i_q <= cmd.first ? ti_c : acc_i_q + ti_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hsum_en) begin
			hs_r_q <= SUM_W'(p_q[0]) - SUM_W'(p_q[1]);
			hs_i_q <= SUM_W'(p_q[2]) + SUM_W'(p_q[3]);
		end
		if (cmd.lsum_en) begin
			ls_r_q <= SUM_W'(yr_q) + SUM_W'(p_q[0] >>> FRAC) - SUM_W'(p_q[1] >>> FRAC);
			ls_i_q <= SUM_W'(yi_q) + SUM_W'(p_q[2] >>> FRAC) + SUM_W'(p_q[3] >>> FRAC);
		end
	end

	always_comb begin
		tot_r_c = hs_r_q + ls_r_q;
		tot_i_c = hs_i_q + ls_i_q;
		sat_r_c = (tot_r_c > Y_MAX) || (tot_r_c < Y_MIN);
		sat_i_c = (tot_i_c > Y_MAX) || (tot_i_c < Y_MIN);
		if (tot_r_c > Y_MAX) begin
			clip_r_c = Y_MAX[COMPONENT_BITS-1:0];
		end else if (tot_r_c < Y_MIN) begin
			clip_r_c = Y_MIN[COMPONENT_BITS-1:0];
		end else begin
			clip_r_c = tot_r_c[COMPONENT_BITS-1:0];
		end
		if (tot_i_c > Y_MAX) begin
			clip_i_c = Y_MAX[COMPONENT_BITS-1:0];
		end else if (tot_i_c < Y_MIN) begin
			clip_i_c = Y_MIN[COMPONENT_BITS-1:0];
		end else begin
			clip_i_c = tot_i_c[COMPONENT_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			new_r_q <= clip_r_c;
			new_i_q <= clip_i_c;
			sat_q   <= sat_r_c || sat_i_c;
			last_q  <= cmd.last_row;
		end
	end

	assign new_y_real = new_r_q;
	assign new_y_imag = new_i_q;
	assign saturated  = sat_q;
	assign last_row   = last_q;

endmodule

### hdl/complex_fused_axpy_columns_unit.sv
`timescale 1ns / 1ps

// A vector load is written to the store as it is accepted. A matrix element passes through
// the shared bank of four 33x33 multipliers in states MUL and ACC; the last column of a row
// also passes FHI, FLO and SUM, since alpha times the 48-bit accumulator runs through the
// same multipliers in two halves, and OUT loads the updated y once the output side is free.
// The result register frees the input side while a finished request waits downstream.
// Asynchronous reset clears the control state and the accumulator and restores register defaults.
module complex_fused_axpy_columns_unit #(
	parameter int MAX_COLUMNS = 8,
	parameter int COMPONENT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [cfaxc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [cfaxc_pkg::CFG_DATA_W-1:0]  wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               opcode,
	input  logic [cfaxc_pkg::SLOT_W-1:0]      column_slot,
	input  logic [COMPONENT_BITS-1:0]          value_real,
	input  logic [COMPONENT_BITS-1:0]          value_imag,
	input  logic [COMPONENT_BITS-1:0]          old_y_real,
	input  logic [COMPONENT_BITS-1:0]          old_y_imag,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [COMPONENT_BITS-1:0]          new_y_real,
	output logic [COMPONENT_BITS-1:0]          new_y_imag,
	output logic                               saturated,
	output logic                               last_row
);

	localparam int IDX_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

	cfaxc_pkg::cfg_t    cfg;
	cfaxc_pkg::dp_cmd_t cmd;
	logic [IDX_W-1:0]   col;

	cfaxc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	cfaxc_ctrl #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.col       (col)
	);

	cfaxc_dpath #(
		.MAX_COLUMNS    (MAX_COLUMNS),
		.COMPONENT_BITS (COMPONENT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.col         (col),
		.column_slot (column_slot),
		.value_real  (value_real),
		.value_imag  (value_imag),
		.old_y_real  (old_y_real),
		.old_y_imag  (old_y_imag),
		.new_y_real  (new_y_real),
		.new_y_imag  (new_y_imag),
		.saturated   (saturated),
		.last_row    (last_row)
	);

endmodule

### tb/tb_complex_fused_axpy_columns_unit.sv
`timescale 1ns / 1ps

package axpy_check_pkg;
	import cfaxc_pkg::*;

	typedef struct {
		logic [31:0] re;
		logic [31:0] im;
		logic        sat;
		logic        last;
	} y_result_t;

	class y_update_checker;
		bit                 conj_m;
		bit                 conj_v;
		logic signed [31:0] alpha_re;
		logic signed [31:0] alpha_im;
		logic [3:0]         col_cnt;
		logic [15:0]        row_cnt;
		logic signed [31:0] x_re [8];
		logic signed [31:0] x_im [8];
		logic signed [47:0] acc_re;
		logic signed [47:0] acc_im;
		int unsigned        col_pos;
		int unsigned        row_pos;
		y_result_t          pending_y [$];
		int                 errors;
		int                 requests;
		int                 results;
		int                 sat_seen;
		int                 calls_done;

		function new();
			conj_m = 0;
			conj_v = 0;
			alpha_re = 0;
			alpha_im = 0;
			col_cnt = 1;
			row_cnt = 1;
			foreach (x_re[i]) begin
				x_re[i] = 0;
				x_im[i] = 0;
			end
			acc_re = 0;
			acc_im = 0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
			requests = 0;
			results = 0;
			sat_seen = 0;
			calls_done = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] d);
			case (idx)
				REG_CONJ_MATRIX:  conj_m = d[0];
				REG_CONJ_VECTOR:  conj_v = d[0];
				REG_ALPHA_REAL:   alpha_re = d;
				REG_ALPHA_IMAG:   alpha_im = d;
				REG_COLUMN_COUNT: col_cnt = d[3:0];
				REG_ROW_COUNT:    row_cnt = d[15:0];
				default: ;
			endcase
		endfunction

		// Q15.16 product, exact and then floored by the fraction width.
		static function logic signed [65:0] fix_mul(logic signed [32:0] p,
				logic signed [32:0] q);
			logic signed [65:0] full;
			full = p * q;
			return full >>> FRAC;
		endfunction

		static function logic signed [79:0] fix_mul_wide(logic signed [31:0] a,
				logic signed [47:0] acc);
			logic signed [79:0] full;
			full = a * acc;
			return full >>> FRAC;
		endfunction

		static function logic [31:0] clip32(logic signed [81:0] v, inout bit sat);
			if (v > 82'sh7FFF_FFFF) begin
				sat = 1;
				return 32'h7FFF_FFFF;
			end
			if (v < -82'sh8000_0000) begin
				sat = 1;
				return 32'h8000_0000;
			end
			return v[31:0];
		endfunction

		function void note_request(logic op, logic [2:0] slot, logic [31:0] vr,
				logic [31:0] vi, logic [31:0] yr, logic [31:0] yi);
			logic signed [32:0] ar;
			logic signed [32:0] ai;
			logic signed [32:0] xr;
			logic signed [32:0] xi;
			logic signed [67:0] tr;
			logic signed [67:0] ti;
			logic signed [81:0] nr;
			logic signed [81:0] ni;
			int unsigned        cols;
			int unsigned        col;
			int unsigned        rows;
			y_result_t          r;
			bit                 sat;
			requests++;
			if (op == OP_LOAD) begin
				x_re[slot] = vr;
				x_im[slot] = vi;
				return;
			end
			cols = col_cnt;
			if (cols < 1) cols = 1;
			if (cols > 8) cols = 8;
			col = (col_pos >= cols) ? cols - 1 : col_pos;
			ar = $signed(vr);
			ai = $signed(vi);
			if (conj_m) ai = -ai;
			xr = x_re[col];
			xi = x_im[col];
			if (conj_v) xi = -xi;
			tr = fix_mul(ar, xr) - fix_mul(ai, xi);
			ti = fix_mul(ar, xi) + fix_mul(ai, xr);
			if (col == 0) begin
				acc_re = tr[47:0];
				acc_im = ti[47:0];
			end else begin
				acc_re = acc_re + tr[47:0];
				acc_im = acc_im + ti[47:0];
			end
			if (col + 1 < cols) begin
				col_pos = col + 1;
				return;
			end
			col_pos = 0;
			nr = $signed(yr) + fix_mul_wide(alpha_re, acc_re) - fix_mul_wide(alpha_im, acc_im);
			ni = $signed(yi) + fix_mul_wide(alpha_re, acc_im) + fix_mul_wide(alpha_im, acc_re);
			acc_re = 0;
			acc_im = 0;
			sat = 0;
			r.re = clip32(nr, sat);
			r.im = clip32(ni, sat);
			r.sat = sat;
			rows = (row_cnt == 0) ? 1 : row_cnt;
			if (row_pos + 1 >= rows) begin
				row_pos = 0;
				r.last = 1;
			end else begin
				row_pos++;
				r.last = 0;
			end
			pending_y.push_back(r);
		endfunction

		function void check_result(logic [31:0] re, logic [31:0] im, logic sat, logic last);
			y_result_t e;
			results++;
			if (sat) sat_seen++;
			if (last) calls_done++;
			if (pending_y.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("Unexpected y result (%h, %h) sat=%b last=%b with none pending",
						re, im, sat, last);
				end
				return;
			end
			e = pending_y.pop_front();
			if (re !== e.re || im !== e.im || sat !== e.sat || last !== e.last) begin
				errors++;
				if (errors <= 10) begin
					$display("Mismatch on y result %0d: expected (%h, %h) sat=%b last=%b,",
						results, e.re, e.im, e.sat, e.last);
					$display("  got (%h, %h) sat=%b last=%b", re, im, sat, last);
				end
			end
		endfunction
	endclass
endpackage

module tb_complex_fused_axpy_columns_unit;
	import cfaxc_pkg::*;
	import axpy_check_pkg::*;

	localparam int MAX_CYCLES = 400000;
	localparam int ITEM_GOAL  = 1700;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [2:0]  wr_index = '0;
	logic [31:0] wr_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OP_LOAD;
	logic [2:0]  column_slot = '0;
	logic [31:0] value_real = '0;
	logic [31:0] value_imag = '0;
	logic [31:0] old_y_real = '0;
	logic [31:0] old_y_imag = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] new_y_real;
	logic [31:0] new_y_imag;
	logic        saturated;
	logic        last_row;

	y_update_checker sb = new();
	int              cycles = 0;
	int              items_sent = 0;
	int              settings = 0;
	bit              quiet_in = 0;
	bit              quiet_out = 0;

	complex_fused_axpy_columns_unit #(
		.MAX_COLUMNS(8),
		.COMPONENT_BITS(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.column_slot(column_slot),
		.value_real(value_real),
		.value_imag(value_imag),
		.old_y_real(old_y_real),
		.old_y_imag(old_y_imag),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.new_y_real(new_y_real),
		.new_y_imag(new_y_imag),
		.saturated(saturated),
		.last_row(last_row)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_result(new_y_real, new_y_imag, saturated, last_row);
			end
			if (in_valid && !in_stall) begin
				sb.note_request(opcode, column_slot, value_real, value_imag, old_y_real, old_y_imag);
			end
		end
	end

	function automatic logic [31:0] pick_component();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3, 4, 5: return v;
			default: return {{13{v[19]}}, v[18:0]};
		endcase
	endfunction

	task automatic send_request(logic op, logic [2:0] slot, logic [31:0] vr, logic [31:0] vi,
			logic [31:0] yr, logic [31:0] yi);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 10);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		opcode = op;
		column_slot = slot;
		value_real = vr;
		value_imag = vi;
		old_y_real = yr;
		old_y_imag = yi;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic send_matrix();
		send_request(OP_MATRIX, 3'($urandom_range(0, 7)), pick_component(), pick_component(),
			pick_component(), pick_component());
	endtask

	task automatic send_load(logic [2:0] slot);
		send_request(OP_LOAD, slot, pick_component(), pick_component(), pick_component(),
			pick_component());
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] d);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = d;
		sb.set_reg(idx, d);
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	// Registers change only with nothing in flight, so the pause after the
	// last result covers a row item or load that is still in the datapath.
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_y.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = quiet_out ? 0 : $urandom_range(0, 10);
			repeat (n) begin
				@(negedge clk);
				out_stall = 1'b1;
			end
			@(negedge clk);
			out_stall = 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		while (cycles < MAX_CYCLES) @(posedge clk);
		$display("Run stopped after %0d cycles with %0d y results still pending",
			cycles, sb.pending_y.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		int unsigned cols;
		int          phase_end;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every slot before any matrix request so no empty slot is read.
		send_request(OP_LOAD, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_request(OP_LOAD, 3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
		send_request(OP_LOAD, 3'd2, 32'h0001_0000, 32'h0000_0000, 32'h0, 32'h0);
		for (int s = 3; s < 8; s++) send_load(3'(s));

		// Zero alpha leaves y unchanged.
		send_request(OP_MATRIX, 3'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000);
		wait_idle();

		// Both conjugations on the most negative value, extreme alpha,
		// zero column and row counts.
		write_reg(REG_CONJ_MATRIX, 32'd1);
		write_reg(REG_CONJ_VECTOR, 32'd1);
		write_reg(REG_ALPHA_REAL, 32'h7FFF_FFFF);
		write_reg(REG_ALPHA_IMAG, 32'h8000_0000);
		write_reg(REG_COLUMN_COUNT, 32'd0);
		write_reg(REG_ROW_COUNT, 32'd0);
		send_request(OP_MATRIX, 3'd0, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
		send_request(OP_MATRIX, 3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h8000_0000);
		wait_idle();

		// Column count above the store size uses all eight columns.
		write_reg(REG_CONJ_MATRIX, 32'd0);
		write_reg(REG_ALPHA_REAL, 32'h0001_0000);
		write_reg(REG_ALPHA_IMAG, 32'h0000_0000);
		write_reg(REG_COLUMN_COUNT, 32'd15);
		write_reg(REG_ROW_COUNT, 32'd3);
		repeat (8) send_matrix();
		wait_idle();

		// Shrinking the column count mid-row makes the next matrix request end it.
		write_reg(REG_COLUMN_COUNT, 32'd4);
		repeat (2) send_matrix();
		wait_idle();
		write_reg(REG_COLUMN_COUNT, 32'd2);
		send_matrix();

		while (items_sent < ITEM_GOAL) begin
			wait_idle();
			settings++;
			quiet_in = ($urandom_range(0, 3) == 0);
			quiet_out = ($urandom_range(0, 3) == 0);
			write_reg(REG_CONJ_MATRIX, $urandom_range(0, 1));
			write_reg(REG_CONJ_VECTOR, $urandom_range(0, 1));
			write_reg(REG_ALPHA_REAL, pick_component());
			write_reg(REG_ALPHA_IMAG, pick_component());
			case ($urandom_range(0, 9))
				0: write_reg(REG_COLUMN_COUNT, 32'd0);
				1: write_reg(REG_COLUMN_COUNT, $urandom_range(9, 15));
				2: write_reg(REG_COLUMN_COUNT, 32'd8);
				default: write_reg(REG_COLUMN_COUNT, $urandom_range(1, 8));
			endcase
			case ($urandom_range(0, 7))
				0: write_reg(REG_ROW_COUNT, 32'd0);
				1: write_reg(REG_ROW_COUNT, 32'hFFFF);
				2: write_reg(REG_ROW_COUNT, 32'd1);
				default: write_reg(REG_ROW_COUNT, $urandom_range(2, 12));
			endcase
			cols = sb.col_cnt;
			if (cols < 1) cols = 1;
			if (cols > 8) cols = 8;
			phase_end = items_sent + $urandom_range(80, 160);
			if (phase_end > ITEM_GOAL) phase_end = ITEM_GOAL;
			while (items_sent < phase_end) begin
				case ($urandom_range(0, 9))
					0: send_load(3'($urandom_range(0, 7)));
					1: send_matrix();
					2: for (int s = 0; s < cols; s++) send_load(3'(s));
					default: repeat (cols) send_matrix();
				endcase
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending_y.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Covered %0d requests and %0d y results over %0d random settings",
			sb.requests, sb.results, settings);
		$display("plus directed cases; saw %0d saturated results, %0d completed calls, %0d mismatches.",
			sb.sat_seen, sb.calls_done, sb.errors);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
